[rtl/timer_min_heap_lazy_cancel_assert.svh]
// ----------------------------------------------------------------------------
// Timer heap assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TIMER_MIN_HEAP_LAZY_CANCEL_ASSERT_SVH
`define TIMER_MIN_HEAP_LAZY_CANCEL_ASSERT_SVH

// property that must hold at every edge
`define TMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle consequence of a condition
`define TMH_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/tmh_pkg.sv]
// ----------------------------------------------------------------------------
// Timer heap package
// Sizes, entry type, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tmh_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int ID_BITS    = 8;
  localparam int TIME_BITS  = 48;
  localparam int ID_SPAN    = 1 << ID_BITS;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CHD_W      = IDX_W + 2;

  typedef struct packed {
    logic [TIME_BITS-1:0] when;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  typedef enum logic [1:0] {
    MODE_SCHED  = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_POP    = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NODUE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCHED_INIT,
    CMD_FULL,
    CMD_CANCEL,
    CMD_UP_RD,
    CMD_UP_MOVE,
    CMD_UP_PLACE,
    CMD_DROP,
    CMD_POP,
    CMD_NODUE,
    CMD_LAST_RD,
    CMD_LAST_LD,
    CMD_DN_RD,
    CMD_DN_STEP,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  k_zero;
    logic  cnt_zero;
    logic  root_marked;
    logic  due;
    logic  up_swap;
    logic  dn_done;
    logic  out_free;
  } sts_t;

endpackage

[rtl/tmh_ctrl.sv]
// ----------------------------------------------------------------------------
// Timer heap controller
// Sequences schedule, cancel, pop, query and pruning over the heap datapath.
// ----------------------------------------------------------------------------
module tmh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tmh_pkg::sts_t sts_i,
  output tmh_pkg::cmd_t cmd_o
);
  import tmh_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISPATCH = 12'b0000_0000_0010,
    S_UP_CHK   = 12'b0000_0000_0100,
    S_UP_CMP   = 12'b0000_0000_1000,
    S_PRUNE1   = 12'b0000_0001_0000,
    S_PRUNE    = 12'b0000_0010_0000,
    S_TAKE     = 12'b0000_0100_0000,
    S_TAKE_LD  = 12'b0000_1000_0000,
    S_DN_RD    = 12'b0001_0000_0000,
    S_DN_CMP   = 12'b0010_0000_0000,
    S_FINISH   = 12'b0100_0000_0000,
    S_TAKE_RD  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ret_pre_q, ret_pre_d;  // removal returns to the pre-pop prune

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    ret_pre_d = ret_pre_q;
    cmd_o.op  = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.mode)
          MODE_SCHED: begin
            if (sts_i.full) begin
              cmd_o.op = CMD_FULL;
              state_d  = S_PRUNE;
            end else begin
              cmd_o.op = CMD_SCHED_INIT;
              state_d  = S_UP_CHK;
            end
          end
          MODE_CANCEL: begin
            cmd_o.op = CMD_CANCEL;
            state_d  = S_PRUNE;
          end
          MODE_POP:   state_d = S_PRUNE1;
          MODE_QUERY: state_d = S_PRUNE;
          default:    state_d = S_PRUNE;
        endcase
      end
      S_UP_CHK: begin
        if (sts_i.k_zero) begin
          cmd_o.op = CMD_UP_PLACE;
          state_d  = S_PRUNE;
        end else begin
          cmd_o.op = CMD_UP_RD;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.up_swap) begin
          cmd_o.op = CMD_UP_MOVE;
          state_d  = S_UP_CHK;
        end else begin
          cmd_o.op = CMD_UP_PLACE;
          state_d  = S_PRUNE;
        end
      end
      S_PRUNE1: begin
        if (sts_i.root_marked) begin
          cmd_o.op  = CMD_DROP;
          ret_pre_d = 1'b1;
          state_d   = S_TAKE;
        end else if (!sts_i.cnt_zero && sts_i.due) begin
          cmd_o.op  = CMD_POP;
          ret_pre_d = 1'b0;
          state_d   = S_TAKE;
        end else begin
          cmd_o.op = CMD_NODUE;
          state_d  = S_PRUNE;
        end
      end
      S_PRUNE: begin
        if (sts_i.root_marked) begin
          cmd_o.op  = CMD_DROP;
          ret_pre_d = 1'b0;
          state_d   = S_TAKE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_TAKE: begin
        if (sts_i.cnt_zero) begin
          state_d = ret_pre_q ? S_PRUNE1 : S_PRUNE;
        end else begin
          cmd_o.op = CMD_LAST_RD;
          state_d  = S_TAKE_RD;
        end
      end
      S_TAKE_RD: state_d = S_TAKE_LD;  // read data lands this cycle
      S_TAKE_LD: begin
        cmd_o.op = CMD_LAST_LD;
        state_d  = S_DN_RD;
      end
      S_DN_RD: begin
        cmd_o.op = CMD_DN_RD;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.op = CMD_DN_STEP;
        if (sts_i.dn_done) begin
          state_d = ret_pre_q ? S_PRUNE1 : S_PRUNE;
        end else begin
          state_d = S_DN_RD;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op = CMD_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_pre_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_pre_q <= ret_pre_d;
    end
  end

`include "timer_min_heap_lazy_cancel_assert.svh"
  `TMH_ASSERT_NEXT(a_accept_dispatch, in_valid_i && !in_stall_o, state_q == S_DISPATCH, "accept did not dispatch")
  `TMH_ASSERT(a_emit_finish, (cmd_o.op != CMD_EMIT) || (state_q == S_FINISH), "emit outside finish")
  `TMH_ASSERT(a_step_in_cmp, (cmd_o.op != CMD_DN_STEP) || (state_q == S_DN_CMP), "sift step outside compare")

endmodule

[rtl/tmh_dp.sv]
// ----------------------------------------------------------------------------
// Timer heap datapath
// Heap RAM, root copy, cancel marks, counters and result registers.
// ----------------------------------------------------------------------------
module tmh_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmh_pkg::cmd_t                 cmd_i,
  output tmh_pkg::sts_t                 sts_o,
  input  logic [1:0]                    mode_i,
  input  logic [tmh_pkg::TIME_BITS-1:0] deadline_i,
  input  logic [tmh_pkg::ID_BITS-1:0]   timer_id_i,
  input  logic [tmh_pkg::TIME_BITS-1:0] now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    op_status_o,
  output logic                          id_valid_o,
  output logic [tmh_pkg::ID_BITS-1:0]   result_id_o,
  output logic                          heap_empty_o,
  output logic [tmh_pkg::TIME_BITS-1:0] next_deadline_o
);
  import tmh_pkg::*;

  entry_t heap_mem [HEAP_DEPTH];
  logic   marks_q [ID_SPAN];

  mode_e                mode_q;
  logic [TIME_BITS-1:0] dl_q, now_q;
  logic [ID_BITS-1:0]   cid_q;
  entry_t               ent_q, root_q, rd_a_q, rd_b_q;
  logic [IDX_W-1:0]     k_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [ID_BITS-1:0]   nid_q;
  status_e              st_q;
  logic                 vl_q;
  logic [ID_BITS-1:0]   rid_q;

  logic                 out_valid_q, out_empty_q, out_idv_q;
  logic [1:0]           out_st_q;
  logic [ID_BITS-1:0]   out_rid_q;
  logic [TIME_BITS-1:0] out_nd_q;

  logic [IDX_W-1:0]     parent;
  logic [CHD_W-1:0]     lc, rc, cnt_x;
  logic                 l_ok, r_ok, best_l, best_r;
  logic [TIME_BITS-1:0] best_when;
  logic                 we;
  logic [IDX_W-1:0]     waddr, ra_addr, rb_addr;
  entry_t               wdata;
  logic                 re;

  assign parent    = (k_q - IDX_W'(1)) >> 1;
  assign lc        = {1'b0, k_q, 1'b1};
  assign rc        = lc + CHD_W'(1);
  assign cnt_x     = CHD_W'(cnt_q);
  assign l_ok      = lc < cnt_x;
  assign r_ok      = rc < cnt_x;
  assign best_l    = l_ok && (rd_a_q.when < ent_q.when);
  assign best_when = best_l ? rd_a_q.when : ent_q.when;
  assign best_r    = r_ok && (rd_b_q.when < best_when);

  assign sts_o.mode        = mode_q;
  assign sts_o.full        = (cnt_q == CNT_W'(HEAP_DEPTH));
  assign sts_o.k_zero      = (k_q == '0);
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.root_marked = (cnt_q != '0) && marks_q[root_q.id];
  assign sts_o.due         = !(root_q.when > now_q);
  assign sts_o.up_swap     = ent_q.when < rd_a_q.when;
  assign sts_o.dn_done     = !best_l && !best_r;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  // one write and two read addresses per cycle
  always_comb begin
    we      = 1'b0;
    waddr   = k_q;
    wdata   = ent_q;
    re      = 1'b0;
    ra_addr = parent;
    rb_addr = rc[IDX_W-1:0];
    unique case (cmd_i.op)
      CMD_UP_MOVE: begin
        we    = 1'b1;
        wdata = rd_a_q;
      end
      CMD_UP_PLACE: we = 1'b1;
      CMD_DN_STEP: begin
        we    = 1'b1;
        wdata = best_r ? rd_b_q : (best_l ? rd_a_q : ent_q);
      end
      CMD_UP_RD: re = 1'b1;
      CMD_LAST_RD: begin
        re      = 1'b1;
        ra_addr = cnt_q[IDX_W-1:0];
      end
      CMD_DN_RD: begin
        re      = 1'b1;
        ra_addr = lc[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_q <= heap_mem[ra_addr];
      rd_b_q <= heap_mem[rb_addr];
    end
    if (we && (waddr == '0)) begin
      root_q <= wdata;
    end
  end

  // payload and scratch
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_LOAD: begin
        mode_q <= mode_e'(mode_i);
        dl_q   <= deadline_i;
        now_q  <= now_time_i;
        cid_q  <= timer_id_i;
        st_q   <= ST_OK;
        vl_q   <= 1'b0;
        rid_q  <= '0;
      end
      CMD_SCHED_INIT: begin
        ent_q <= '{when: dl_q, id: nid_q};
        k_q   <= cnt_q[IDX_W-1:0];
        vl_q  <= 1'b1;
        rid_q <= nid_q;
      end
      CMD_FULL:    st_q <= ST_FULL;
      CMD_NODUE:   st_q <= ST_NODUE;
      CMD_UP_MOVE: k_q  <= parent;
      CMD_POP: begin
        vl_q  <= 1'b1;
        rid_q <= root_q.id;
      end
      CMD_LAST_LD: begin
        ent_q <= rd_a_q;
        k_q   <= '0;
      end
      CMD_DN_STEP: begin
        if (best_r) begin
          k_q <= rc[IDX_W-1:0];
        end else if (best_l) begin
          k_q <= lc[IDX_W-1:0];
        end
      end
      default: ;
    endcase
    if (cmd_i.op == CMD_EMIT) begin
      out_st_q  <= st_q;
      out_idv_q <= vl_q;
      out_rid_q <= rid_q;
      out_empty_q <= (cnt_q == '0);
      out_nd_q  <= (cnt_q == '0) ? '0 : root_q.when;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      nid_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ID_SPAN; i++) begin
        marks_q[i] <= 1'b0;
      end
    end else begin
      unique case (cmd_i.op)
        CMD_SCHED_INIT: begin
          cnt_q          <= cnt_q + CNT_W'(1);
          nid_q          <= nid_q + ID_BITS'(1);
          marks_q[nid_q] <= 1'b0;
        end
        CMD_CANCEL: marks_q[cid_q] <= 1'b1;
        CMD_DROP: begin
          marks_q[root_q.id] <= 1'b0;
          cnt_q              <= cnt_q - CNT_W'(1);
        end
        CMD_POP: cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
      if (cmd_i.op == CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign op_status_o     = out_st_q;
  assign id_valid_o      = out_idv_q;
  assign result_id_o     = out_rid_q;
  assign heap_empty_o    = out_empty_q;
  assign next_deadline_o = out_nd_q;

`include "timer_min_heap_lazy_cancel_assert.svh"
  `TMH_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(HEAP_DEPTH), "entry count above depth")
  `TMH_ASSERT_NEXT(a_sched_cnt, cmd_i.op == CMD_SCHED_INIT, cnt_q == $past(cnt_q) + CNT_W'(1), "schedule did not grow heap")
  `TMH_ASSERT_NEXT(a_drop_clears, cmd_i.op == CMD_DROP, !marks_q[$past(root_q.id)], "dropped root mark still set")

endmodule

[rtl/timer_min_heap_lazy_cancel.sv]
// ----------------------------------------------------------------------------
// Timer min-heap with lazy cancel
// Binary min-heap timer queue: schedule, cancel, pop-due and query.
// ----------------------------------------------------------------------------
// One operation at a time. An input transfer is taken only when the block is
// idle. The result goes to an output register, so the next operation may
// start while it waits. Input is held off at the end of an operation only
// while that register is still full and stalled. A schedule places the new
// entry at the end and lets it climb past each larger parent. Popping or
// dropping the root reads the last entry, loads it at the top and lets it
// sink to its smaller child until no child is smaller. Each step goes through
// the single heap RAM, whose reads are registered. A 64-entry heap has 7
// levels, and every cancelled root reaching the top adds one removal.
// Cancel marks live in flip-flops cleared at reset; heap storage needs no
// clearing.
module timer_min_heap_lazy_cancel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [tmh_pkg::TIME_BITS-1:0] deadline_i,
  input  logic [tmh_pkg::ID_BITS-1:0]   timer_id_i,
  input  logic [tmh_pkg::TIME_BITS-1:0] now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    op_status_o,
  output logic                          id_valid_o,
  output logic [tmh_pkg::ID_BITS-1:0]   result_id_o,
  output logic                          heap_empty_o,
  output logic [tmh_pkg::TIME_BITS-1:0] next_deadline_o
);
  import tmh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmh_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .deadline_i      (deadline_i),
    .timer_id_i      (timer_id_i),
    .now_time_i      (now_time_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .op_status_o     (op_status_o),
    .id_valid_o      (id_valid_o),
    .result_id_o     (result_id_o),
    .heap_empty_o    (heap_empty_o),
    .next_deadline_o (next_deadline_o)
  );

endmodule
